### rtl/core/wfc_pkg.sv
// Shared constants, types and helper functions of the word frequency counter.
package wfc_pkg;

  // Sizing of the word buffer, the word table and the counters.
  localparam int WORD_CHARS  = 11;
  localparam int TABLE_DEPTH = 64;
  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;

  // Derived widths.
  localparam int LEN_W   = $clog2(WORD_CHARS + 1);
  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W  = $clog2(TABLE_DEPTH + 1);
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Fixed widths of the result fields.
  localparam int ENTRY_W     = 6;
  localparam int COUNT_OUT_W = 16;

  // Punctuation that is dropped from words, and the case-folding constants.
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_PERIOD   = 8'h2E;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Count value of a freshly inserted entry.
  localparam logic [COUNT_BITS-1:0] COUNT_FIRST = COUNT_BITS'(1);

  // Lookup key: folded characters, zero past the length, plus the length.
  typedef struct packed {
    logic [WORD_CHARS-1:0][7:0] chars;
    logic [LEN_W-1:0]           len;
  } key_t;

  // One finished word travelling from the front to the back.
  typedef struct packed {
    key_t key;
    logic overlong;
  } word_t;

  // One result transaction.
  typedef struct packed {
    logic [ENTRY_W-1:0]     entry_index;
    logic [COUNT_OUT_W-1:0] count;
    logic                   new_word;
    logic                   table_full;
    logic                   truncated;
  } result_t;

  // Fold upper-case ASCII letters to lower case; every other byte is kept.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  // True for the punctuation characters that are dropped.
  function automatic logic is_dropped(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_PERIOD) || (c == CH_QUESTION);
  endfunction

endpackage

### rtl/core/wfc_front.sv
// Front end: collects characters into a folded word and hands finished words on.
module wfc_front import wfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_word_i,
  output logic       push_o,
  output word_t      push_word_o,
  input  logic       push_ready_i
);

  logic [WORD_CHARS-1:0][7:0] chars_q, chars_d;
  logic [LEN_W-1:0]           len_q, len_d;
  logic                       over_q, over_d;
  logic                       accept;

  // A character is taken whenever the queue has room for a possible word end.
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Append the folded character, or mark the word as overlong when full.
  always_comb begin
    chars_d = chars_q;
    len_d   = len_q;
    over_d  = over_q;
    if (!is_dropped(char_in_i)) begin
      if (len_q < LEN_W'(WORD_CHARS)) begin
        for (int i = 0; i < WORD_CHARS; i++) begin
          if (len_q == LEN_W'(i)) begin
            chars_d[i] = fold(char_in_i);
          end
        end
        len_d = len_q + LEN_W'(1);
      end else begin
        over_d = 1'b1;
      end
    end
  end

  // The finished word leaves in the transaction that carries its last character.
  assign push_o                = accept && end_of_word_i;
  assign push_word_o.key.chars = chars_d;
  assign push_word_o.key.len   = len_d;
  assign push_word_o.overlong  = over_d;

  // Word buffer: cleared after each word end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= '0;
      len_q   <= '0;
      over_q  <= 1'b0;
    end else if (accept) begin
      if (end_of_word_i) begin
        chars_q <= '0;
        len_q   <= '0;
        over_q  <= 1'b0;
      end else begin
        chars_q <= chars_d;
        len_q   <= len_d;
        over_q  <= over_d;
      end
    end
  end

endmodule

### rtl/core/wfc_queue.sv
// Short word queue that decouples the character front end from the table lookup.
module wfc_queue import wfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  word_t push_word_i,
  output logic  push_ready_o,
  input  logic  pop_i,
  output word_t pop_word_o,
  output logic  pop_valid_o
);

  word_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] fill_q;
  logic              do_push, do_pop;

  assign push_ready_o = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_word_o   = slots_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Storage for queued words.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_word_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/wfc_back.sv
// Back end: scans the word table, updates or inserts, and holds the result.
module wfc_back import wfc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   word_valid_i,
  input  word_t                  word_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ENTRY_W-1:0]     entry_index_o,
  output logic [COUNT_OUT_W-1:0] count_o,
  output logic                   new_word_o,
  output logic                   table_full_o,
  output logic                   truncated_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  word_t                   work_q, work_d;
  logic [USED_W-1:0]       idx_q, idx_d;
  logic [USED_W-1:0]       used_q, used_d;
  result_t                 res_q, res_d;

  // Table memories and their registered read data.
  key_t                    key_mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]   cnt_mem [TABLE_DEPTH];
  key_t                    key_rd_q;
  logic [COUNT_BITS-1:0]   cnt_rd_q;

  logic                    rd_en;
  logic                    key_we, cnt_we;
  logic [IDX_W-1:0]        wr_addr;
  logic [COUNT_BITS-1:0]   cnt_wdata;
  logic [COUNT_BITS-1:0]   cnt_inc;

  // Saturating increment of the entry that was read.
  assign cnt_inc = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);

  // Scan sequencer: each table entry passes through the read and compare states, first match wins.
  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    idx_d     = idx_q;
    used_d    = used_q;
    res_d     = res_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    wr_addr   = idx_q[IDX_W-1:0];
    cnt_wdata = cnt_inc;
    case (state_q)
      S_IDLE: begin
        if (word_valid_i) begin
          pop_o   = 1'b1;
          work_d  = word_i;
          idx_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        res_d.truncated = work_q.overlong;
        if (idx_q == used_q) begin
          // No stored entry matched: insert or report a full table.
          if (used_q < USED_W'(TABLE_DEPTH)) begin
            key_we            = 1'b1;
            cnt_we            = 1'b1;
            wr_addr           = used_q[IDX_W-1:0];
            cnt_wdata         = COUNT_FIRST;
            used_d            = used_q + USED_W'(1);
            res_d.entry_index = ENTRY_W'(used_q[IDX_W-1:0]);
            res_d.count       = COUNT_OUT_W'(COUNT_FIRST);
            res_d.new_word    = 1'b1;
            res_d.table_full  = 1'b0;
          end else begin
            res_d.entry_index = '0;
            res_d.count       = '0;
            res_d.new_word    = 1'b0;
            res_d.table_full  = 1'b1;
          end
          state_d = S_OUT;
        end else begin
          rd_en   = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (key_rd_q == work_q.key) begin
          cnt_we            = 1'b1;
          res_d.entry_index = ENTRY_W'(idx_q[IDX_W-1:0]);
          res_d.count       = COUNT_OUT_W'(cnt_inc);
          res_d.new_word    = 1'b0;
          res_d.table_full  = 1'b0;
          state_d           = S_OUT;
        end else begin
          idx_d   = idx_q + USED_W'(1);
          state_d = S_READ;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Key memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= work_q.key;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[idx_q[IDX_W-1:0]];
    end
  end

  // Count memory: read alongside the key, written on a hit or an insert.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    if (rd_en) begin
      cnt_rd_q <= cnt_mem[idx_q[IDX_W-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      used_q  <= used_d;
    end
  end

  // Working word and result payload.
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    res_q  <= res_d;
  end

  assign out_valid_o   = (state_q == S_OUT);
  assign entry_index_o = res_q.entry_index;
  assign count_o       = res_q.count;
  assign new_word_o    = res_q.new_word;
  assign table_full_o  = res_q.table_full;
  assign truncated_o   = res_q.truncated;

`ifndef SYNTHESIS
  // The fill count never runs past the table size.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // The fill count only grows by one, and only when an insert result is shown.
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      ((used_q == $past(used_q) + USED_W'(1)) && out_valid_o && new_word_o))
    else $error("entry count changed without an insert");

  // A full-table report only happens when every entry is in use.
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (used_q == USED_W'(TABLE_DEPTH)))
    else $error("table full reported with free entries");

  // A counted word never shows a zero count, and is never both new and full.
  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !table_full_o) |-> ((count_o != '0) || (COUNT_BITS > COUNT_OUT_W)))
    else $error("counted word has zero count");

  a_new_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(new_word_o && table_full_o))
    else $error("result is both new and table full");
`endif

endmodule

### rtl/core/word_frequency_counter.sv
// Word frequency counter: character stream in, one lookup result per word out.
//
// Input channel (in_valid_i / in_ready_o): one byte per transaction, with
// end_of_word_i marking the last byte of a word. Commas, periods and question
// marks are dropped; A..Z fold to lower case; up to WORD_CHARS bytes are kept.
// Output channel (out_valid_o / out_ready_i): one transaction per word, giving
// the table slot, the saturating count and the new, full and truncated flags.
//
// Characters are taken one per cycle while the word queue has room. A word end
// is looked up by a scan of the table, each stored entry in turn passing
// through a read and a compare state. The word leaves the queue at the earliest
// in the cycle after its last byte is taken; its result is registered when the
// scan hits, or after it has passed all stored words on a miss. The next word
// leaves the queue in the cycle after the result is accepted. That scan sets
// the word rate; a 2-entry queue lets characters keep flowing during it. A
// stalled receiver holds the result register and the scan stops; the front
// keeps taking characters until the queue fills.
// Reset empties the table at once (a fill count marks the used entries), so
// there is no clearing pass and the block is ready as soon as reset is released.
module word_frequency_counter import wfc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             char_in_i,
  input  logic                   end_of_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ENTRY_W-1:0]     entry_index_o,
  output logic [COUNT_OUT_W-1:0] count_o,
  output logic                   new_word_o,
  output logic                   table_full_o,
  output logic                   truncated_o
);

  logic  push, push_ready, pop, pop_valid;
  word_t push_word, pop_word;

  // Character collection.
  wfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_in_i     (char_in_i),
    .end_of_word_i (end_of_word_i),
    .push_o        (push),
    .push_word_o   (push_word),
    .push_ready_i  (push_ready)
  );

  // Finished words waiting for lookup.
  wfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_word_i  (push_word),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_word_o   (pop_word),
    .pop_valid_o  (pop_valid)
  );

  // Table lookup, update and result.
  wfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_valid_i  (pop_valid),
    .word_i        (pop_word),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .entry_index_o (entry_index_o),
    .count_o       (count_o),
    .new_word_o    (new_word_o),
    .table_full_o  (table_full_o),
    .truncated_o   (truncated_o)
  );

endmodule
